>>> rtl/core/b64_pkg.sv
// Shared types and the character lookup for the Base64 stream decoder.
package b64_pkg;

   // Kind of one incoming character
   typedef enum logic [1:0] {
      CH_DATA,
      CH_PAD,
      CH_BAD
   } char_kind_type;

   // Classified character: kind plus its 6-bit value for alphabet characters
   typedef struct packed {
      char_kind_type kind;
      logic [5:0]    value;
   } sextet_type;

   // Results raised by one accepted character: up to three bytes, then status
   typedef struct packed {
      logic [1:0]      byte_cnt;
      logic [2:0][7:0] bytes;
      logic            status;
      logic            err;
   } bundle_type;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Bundles held between the decode stage and the result serialiser
   localparam int unsigned QUEUE_DEPTH = 4;

   // Map a raw byte to its alphabet value
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.kind  = CH_DATA;
      s.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         s.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         s.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         s.value = 6'd62;
      end else if (c == 8'h2F) begin
         s.value = 6'd63;
      end else if (c == PAD_CHAR) begin
         s.kind = CH_PAD;
      end else begin
         s.kind = CH_BAD;
      end
      return s;
   endfunction

endpackage

>>> rtl/core/b64_decode.sv
// Message state and per-character decode into a bundle of results.
module b64_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_in,
   input  logic                last_char,
   output logic                push,
   output b64_pkg::bundle_type bundle
);

   logic [17:0] group_bits_ff, group_bits_in;
   logic [1:0]  group_count_ff, group_count_in;
   logic [1:0]  pad_count_ff, pad_count_in;
   logic        error_seen_ff, error_seen_in;

   b64_pkg::sextet_type sx;
   logic [23:0]         word;
   logic                ok;

   // Classify the character and work out the next state and the results
   always_comb begin
      sx             = b64_pkg::sextet_of(char_in);
      word           = {group_bits_ff, sx.value};
      group_bits_in  = group_bits_ff;
      group_count_in = group_count_ff;
      pad_count_in   = pad_count_ff;
      error_seen_in  = error_seen_ff;
      bundle         = '0;
      ok             = 1'b0;

      case (sx.kind)
         b64_pkg::CH_BAD: begin
            error_seen_in = 1'b1;
         end
         b64_pkg::CH_PAD: begin
            if (pad_count_ff == 2'd2) error_seen_in = 1'b1;
            else pad_count_in = pad_count_ff + 2'd1;
         end
         default: begin
            if (pad_count_ff != 2'd0) begin
               error_seen_in = 1'b1;
            end else if (group_count_ff == 2'd3) begin
               // complete group: three bytes, high byte first
               if (!error_seen_ff) begin
                  bundle.byte_cnt = 2'd3;
                  bundle.bytes[0] = word[23:16];
                  bundle.bytes[1] = word[15:8];
                  bundle.bytes[2] = word[7:0];
               end
               group_bits_in  = '0;
               group_count_in = 2'd0;
            end else begin
               group_bits_in  = {group_bits_ff[11:0], sx.value};
               group_count_in = group_count_ff + 2'd1;
            end
         end
      endcase

      // Close the message: trailing bytes of a padded group, then status
      if (last_char) begin
         ok = !error_seen_in &&
              ((pad_count_in == 2'd0 && group_count_in == 2'd0) ||
               (pad_count_in == 2'd1 && group_count_in == 2'd3) ||
               (pad_count_in == 2'd2 && group_count_in == 2'd2));
         if (ok && group_count_in == 2'd3) begin
            bundle.byte_cnt = 2'd2;
            bundle.bytes[0] = group_bits_in[17:10];
            bundle.bytes[1] = group_bits_in[9:2];
         end else if (ok && group_count_in == 2'd2) begin
            bundle.byte_cnt = 2'd1;
            bundle.bytes[0] = group_bits_in[11:4];
         end
         bundle.status  = 1'b1;
         bundle.err     = !ok;
         group_bits_in  = '0;
         group_count_in = 2'd0;
         pad_count_in   = 2'd0;
         error_seen_in  = 1'b0;
      end

      push = accept && (bundle.status || bundle.byte_cnt != 2'd0);
   end

   // Hold message state; advance on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         group_bits_ff  <= '0;
         group_count_ff <= 2'd0;
         pad_count_ff   <= 2'd0;
         error_seen_ff  <= 1'b0;
      end else if (accept) begin
         group_bits_ff  <= group_bits_in;
         group_count_ff <= group_count_in;
         pad_count_ff   <= pad_count_in;
         error_seen_ff  <= error_seen_in;
      end
   end

endmodule

>>> rtl/core/base64_stream_decoder.sv
// Top level of the Base64 stream decoder: decode stage, bundle queue, result serialiser.
//
// Usage:
//   The req_ channel takes one encoded character per beat in req_tdata[7:0];
//   req_tlast marks the final character of a message. The rsp_ channel gives
//   one result per beat: a decoded byte, or the status beat that closes a
//   message (rsp_tuser[1] set, rsp_tdata[8] set when the message is invalid
//   and its bytes must be discarded). rsp_tlast marks the last result raised
//   by one input character.
// Flow and throughput:
//   A character is accepted every cycle while the four-entry bundle queue has
//   room. Its results are queued and appear on rsp_ once the results ahead
//   of them have been taken. Each result takes one rsp_ beat; four characters
//   yield at most three bytes, and the stream can run at one character per
//   cycle on average while rsp_tready stays high, the rsp_ serialiser
//   draining one result per cycle.
// Reset and stall:
//   Reset empties the queue and clears the message state. While rsp_tready is
//   low the current result holds; req_tready drops once the queue is full.
module base64_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] message_error, rest zero
   output logic [1:0]  rsp_tuser,   // [0] byte_present, [1] message_end
   output logic        rsp_tlast    // last_of_run
);

   logic                req_accept;
   logic                rsp_accept;
   logic                push;
   logic                pop;
   b64_pkg::bundle_type bundle;
   b64_pkg::bundle_type head;

   b64_pkg::bundle_type queue_ff [b64_pkg::QUEUE_DEPTH];
   logic [1:0]          wr_ptr_ff, wr_ptr_in;
   logic [1:0]          rd_ptr_ff, rd_ptr_in;
   logic [2:0]          count_ff, count_in;
   logic [1:0]          idx_ff, idx_in;

   logic [2:0]          total;
   logic                at_last;

   assign req_tready = (count_ff != 3'(b64_pkg::QUEUE_DEPTH));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   b64_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .char_in   (req_tdata),
      .last_char (req_tlast),
      .push      (push),
      .bundle    (bundle)
   );

   // Pick the current result out of the head bundle
   always_comb begin
      head       = queue_ff[rd_ptr_ff];
      total      = {1'b0, head.byte_cnt} + {2'b00, head.status};
      at_last    = ({1'b0, idx_ff} + 3'd1) == total;
      rsp_tvalid = (count_ff != 3'd0);
      rsp_tlast  = at_last;
      rsp_tdata  = '0;
      rsp_tuser  = '0;
      if (idx_ff < head.byte_cnt) begin
         rsp_tdata[7:0] = head.bytes[idx_ff];
         rsp_tuser[0]   = 1'b1;
      end else begin
         rsp_tdata[8] = head.err;
         rsp_tuser[1] = 1'b1;
      end
   end

   // Advance pointers, count and result index
   always_comb begin
      pop       = rsp_accept && at_last;
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'b00, push} - {2'b00, pop};
      if (pop) idx_in = 2'd0;
      else if (rsp_accept) idx_in = idx_ff + 2'd1;
      else idx_in = idx_ff;
   end

   // Hold queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
         idx_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
      end
   end

   // Store a bundle at the write pointer
   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= bundle;
   end

endmodule

>>> test/tb.sv
// Self-checking stream testbench for the Base64 stream decoder.
module tb;

   localparam int RANDOM_ITEMS   = 184;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 20;

   // One result beat, split into its fields
   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       msg_end;
      logic       msg_err;
      logic       run_last;
   } beat_type;

   // One directed row: character, last mark, and an optional typed status
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       typed;
      logic       t_err;
   } dir_row_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_THREE_OF_FOUR,
      RX_COIN,
      RX_SPARSE
   } rx_mode_type;

   localparam int NUM_DIRECTED = 26;
   localparam dir_row_type DIRECTED [NUM_DIRECTED] = '{
      // alphabet corners in one full group
      '{"+", 1'b0, 1'b0, 1'b0}, '{"/", 1'b0, 1'b0, 1'b0},
      '{"9", 1'b0, 1'b0, 1'b0}, '{"z", 1'b1, 1'b0, 1'b0},
      // one pad, two trailing bytes
      '{"T", 1'b0, 1'b0, 1'b0}, '{"W", 1'b0, 1'b0, 1'b0},
      '{"E", 1'b0, 1'b0, 1'b0}, '{"=", 1'b1, 1'b0, 1'b0},
      // two pads, one trailing byte
      '{"T", 1'b0, 1'b0, 1'b0}, '{"Q", 1'b0, 1'b0, 1'b0},
      '{"=", 1'b0, 1'b0, 1'b0}, '{"=", 1'b1, 1'b0, 1'b0},
      // data after padding
      '{"=", 1'b0, 1'b0, 1'b0}, '{"A", 1'b1, 1'b1, 1'b1},
      // too much padding
      '{"=", 1'b0, 1'b0, 1'b0}, '{"=", 1'b0, 1'b0, 1'b0},
      '{"=", 1'b1, 1'b1, 1'b1},
      // stray single character
      '{"Z", 1'b1, 1'b1, 1'b1},
      // unpadded partial group
      '{"T", 1'b0, 1'b0, 1'b0}, '{"W", 1'b0, 1'b0, 1'b0},
      '{"E", 1'b1, 1'b1, 1'b1},
      // invalid byte, then a full group that must emit no bytes
      '{8'hFF, 1'b0, 1'b0, 1'b0}, '{"A", 1'b0, 1'b0, 1'b0},
      '{"Z", 1'b0, 1'b0, 1'b0}, '{"a", 1'b0, 1'b0, 1'b0},
      '{"z", 1'b1, 1'b1, 1'b1}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] char_in
   logic        req_tlast;   // last_char
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] out_byte, [8] message_error, rest zero
   logic [1:0]  rsp_tuser;   // [0] byte_present, [1] message_end
   logic        rsp_tlast;   // last_of_run

   // tb-side tags that travel with each offered character
   logic        req_typed;
   logic        req_terr;

   // decoder state mirror
   logic [17:0] grp_bits;
   logic [1:0]  grp_cnt;
   logic [1:0]  pad_cnt;
   logic        bad_seen;

   beat_type    run_beats[$];
   beat_type    expected_beats[$];
   int          error_count;
   int          idle_cycles;
   int          burst_left;
   int          items_sent;
   bit          hold_req;
   bit          hold_done;

   base64_stream_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Classify a raw byte
   function automatic b64_pkg::char_kind_type kind_of(input logic [7:0] c);
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
          c == "+" || c == "/") begin
         return b64_pkg::CH_DATA;
      end
      if (c == b64_pkg::PAD_CHAR) begin
         return b64_pkg::CH_PAD;
      end
      return b64_pkg::CH_BAD;
   endfunction

   // 6-bit value of an alphabet character
   function automatic logic [5:0] sextet_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= "A" && c <= "Z") begin
         v = c - "A";
      end else if (c >= "a" && c <= "z") begin
         v = c - "a" + 8'd26;
      end else if (c >= "0" && c <= "9") begin
         v = c - "0" + 8'd52;
      end else if (c == "+") begin
         v = 8'd62;
      end else if (c == "/") begin
         v = 8'd63;
      end
      return v[5:0];
   endfunction

   // Alphabet character for a 6-bit value
   function automatic logic [7:0] alphabet_char(input logic [5:0] v);
      if (v < 6'd26) begin
         return "A" + 8'(v);
      end
      if (v < 6'd52) begin
         return "a" + 8'(v - 6'd26);
      end
      if (v < 6'd62) begin
         return "0" + 8'(v - 6'd52);
      end
      return (v == 6'd62) ? "+" : "/";
   endfunction

   function automatic beat_type byte_beat(input logic [7:0] b);
      beat_type r;
      r = '{data: b, present: 1'b1, msg_end: 1'b0, msg_err: 1'b0, run_last: 1'b0};
      return r;
   endfunction

   function automatic beat_type status_beat(input logic err);
      beat_type r;
      r = '{data: 8'h00, present: 1'b0, msg_end: 1'b1, msg_err: err, run_last: 1'b0};
      return r;
   endfunction

   task automatic clear_message;
      grp_bits = '0;
      grp_cnt  = '0;
      pad_cnt  = '0;
      bad_seen = 1'b0;
   endtask

   // Decode one character into run_beats and advance the mirror state
   task automatic decode_char(input logic [7:0] ch, input logic last);
      logic [23:0] word;
      logic [5:0]  val;
      logic        ok;
      run_beats.delete();
      val = sextet_value(ch);
      case (kind_of(ch))
         b64_pkg::CH_BAD: begin
            bad_seen = 1'b1;
         end
         b64_pkg::CH_PAD: begin
            if (pad_cnt >= 2'd2) bad_seen = 1'b1;
            else pad_cnt = pad_cnt + 2'd1;
         end
         default: begin
            if (pad_cnt != 2'd0) begin
               bad_seen = 1'b1;
            end else if (grp_cnt == 2'd3) begin
               word = {grp_bits, val};
               if (!bad_seen) begin
                  run_beats.push_back(byte_beat(word[23:16]));
                  run_beats.push_back(byte_beat(word[15:8]));
                  run_beats.push_back(byte_beat(word[7:0]));
               end
               grp_bits = '0;
               grp_cnt  = '0;
            end else begin
               grp_bits = {grp_bits[11:0], val};
               grp_cnt  = grp_cnt + 2'd1;
            end
         end
      endcase

      // close the message: trailing bytes of a padded group, then status
      if (last) begin
         ok = !bad_seen && ((pad_cnt == 2'd0 && grp_cnt == 2'd0) ||
                            (pad_cnt == 2'd1 && grp_cnt == 2'd3) ||
                            (pad_cnt == 2'd2 && grp_cnt == 2'd2));
         if (ok && grp_cnt == 2'd3) begin
            run_beats.push_back(byte_beat(grp_bits[17:10]));
            run_beats.push_back(byte_beat(grp_bits[9:2]));
         end else if (ok && grp_cnt == 2'd2) begin
            run_beats.push_back(byte_beat(grp_bits[11:4]));
         end
         run_beats.push_back(status_beat(!ok));
         clear_message();
      end
      if (run_beats.size() > 0) run_beats[run_beats.size() - 1].run_last = 1'b1;
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // Compare one accepted result beat with the oldest expectation
   task automatic check_beat;
      beat_type got;
      beat_type want;
      got = '{data: rsp_tdata[7:0], present: rsp_tuser[0], msg_end: rsp_tuser[1],
              msg_err: rsp_tdata[8], run_last: rsp_tlast};
      if (expected_beats.size() == 0) begin
         report_mismatch("unexpected beat", got.data, 8'h00);
      end else begin
         want = expected_beats.pop_front();
         if (got.data !== want.data) report_mismatch("out_byte", got.data, want.data);
         if (got.present !== want.present)
            report_mismatch("byte_present", 8'(got.present), 8'(want.present));
         if (got.msg_end !== want.msg_end)
            report_mismatch("message_end", 8'(got.msg_end), 8'(want.msg_end));
         if (got.msg_err !== want.msg_err)
            report_mismatch("message_error", 8'(got.msg_err), 8'(want.msg_err));
         if (got.run_last !== want.run_last)
            report_mismatch("last_of_run", 8'(got.run_last), 8'(want.run_last));
      end
   endtask

   // Check outputs, then predict from the character accepted at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_beat();
         if (req_tvalid && req_tready) begin
            decode_char(req_tdata, req_tlast);
            if (req_typed) expected_beats.push_back('{8'h00, 1'b0, 1'b1, req_terr, 1'b1});
            else foreach (run_beats[i]) expected_beats.push_back(run_beats[i]);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   // Offer one character and hold it until accepted; idle between bursts
   task automatic send_char(input logic [7:0] ch, input logic last,
                            input logic typed, input logic t_err);
      int gap;
      req_tdata  <= ch;
      req_tlast  <= last;
      req_typed  <= typed;
      req_terr   <= t_err;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
      end
   endtask

   // Build one message, mostly well formed, sometimes broken, and send it
   task automatic send_random_message;
      logic [7:0] msg[$];
      int groups;
      int tail;
      int pos;
      groups = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
      tail   = $urandom_range(0, 2);
      if (groups == 0 && tail == 0) groups = 1;
      repeat (groups * 4) msg.push_back(alphabet_char(6'($urandom_range(0, 63))));
      if (tail == 1) begin
         repeat (3) msg.push_back(alphabet_char(6'($urandom_range(0, 63))));
         msg.push_back(b64_pkg::PAD_CHAR);
      end else if (tail == 2) begin
         repeat (2) msg.push_back(alphabet_char(6'($urandom_range(0, 63))));
         msg.push_back(b64_pkg::PAD_CHAR);
         msg.push_back(b64_pkg::PAD_CHAR);
      end

      // break about one message in five
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 4))
            0: begin
               pos = $urandom_range(0, msg.size() - 1);
               msg[pos] = 8'($urandom_range(0, 255));
            end
            1: if (msg.size() > 1) void'(msg.pop_back());
            2: msg.push_back(b64_pkg::PAD_CHAR);
            3: msg.push_back(alphabet_char(6'($urandom_range(0, 63))));
            default: begin
               msg.delete();
               msg.push_back(8'($urandom_range(0, 255)));
            end
         endcase
      end

      foreach (msg[i]) send_char(msg[i], i == msg.size() - 1, 1'b0, 1'b0);
   endtask

   // Receiver: its own stall pattern, plus one long hold-off on request
   initial begin
      rx_mode_type mode;
      int          phase_left;
      int          tick;
      rsp_tready = 1'b0;
      mode       = RX_OPEN;
      phase_left = 0;
      tick       = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_req && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if (phase_left == 0) begin
               mode       = rx_mode_type'($urandom_range(0, 3));
               phase_left = $urandom_range(10, 60);
            end
            phase_left--;
            case (mode)
               RX_OPEN:          rsp_tready <= 1'b1;
               RX_THREE_OF_FOUR: rsp_tready <= (tick % 4) != 0;
               RX_COIN:          rsp_tready <= 1'($urandom_range(0, 1));
               default:          rsp_tready <= (tick % 3) == 0;
            endcase
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      @(negedge reset);
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   // Main sequence: reset, directed rows, random messages, drain
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tlast   = 1'b0;
      req_typed   = 1'b0;
      req_terr    = 1'b0;
      error_count = 0;
      idle_cycles = 0;
      burst_left  = 0;
      items_sent  = 0;
      hold_req    = 1'b0;
      hold_done   = 1'b0;
      clear_message();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_char(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].t_err);
      end

      // random part; ask for the long hold-off partway through
      while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
         if (!hold_req && items_sent >= NUM_DIRECTED + 80) begin
            hold_req   = 1'b1;
            burst_left = 60;
         end
         send_random_message();
      end
      req_tvalid <= 1'b0;

      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/b64_pkg.sv
rtl/core/b64_decode.sv
rtl/core/base64_stream_decoder.sv
test/tb.sv
